[rtl/lrpm_pkg.sv]
package lrpm_pkg;

  // Pixel and level width.
  localparam int unsigned PixW = 16;
  // Ratio format: unsigned Q1.30 for 2*cur/ref.
  localparam int unsigned QFrac = 30;
  localparam int unsigned YW = QFrac + 1;
  // Fraction bits of the log2 result.
  localparam int unsigned LogFracBits = 24;

  localparam logic [PixW-1:0] LevelMax = {PixW{1'b1}};

  // Control that travels with each word down the pipe.
  typedef struct packed {
    logic valid;
    logic sat_hi;
    logic sat_lo;
  } lrpm_tag_t;

endpackage

[rtl/log_ratio_pixel_map_core.sv]
// Pipeline: 1 input stage, 31 divider stages, 24 log2 stages and 1 scaling
// stage lie between input word and output word.
// Throughput: one word per cycle; the whole pipe advances together and
// holds when the output register is full and stalled.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module log_ratio_pixel_map_core
  import lrpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PixW-1:0] cur_pixel_i,
  input  logic [PixW-1:0] ref_pixel_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] log_ratio_level_o
);

  localparam int unsigned ProdW = LogFracBits + PixW;

  // Advance the whole pipe unless the output word is waiting on a stall.
  logic adv;

  // Input stage: zero fix and saturation decisions.
  logic [PixW-1:0] cur_fix, ref_fix;
  lrpm_tag_t       s0_tag_d, s0_tag_q;
  logic [PixW-1:0] s0_cur_q, s0_ref_q;

  // Divider chain: element k feeds divider stage k.
  lrpm_tag_t       div_tag [0:YW];
  logic [PixW-1:0] div_rem [0:YW];
  logic [PixW-1:0] div_den [0:YW];
  logic [YW-1:0]   div_quo [0:YW];

  // Log2 chain: element k feeds log stage k.
  lrpm_tag_t              log_tag  [0:LogFracBits];
  logic [YW-1:0]          log_y    [0:LogFracBits];
  logic [LogFracBits-1:0] log_frac [0:LogFracBits];

  // Output stage.
  lrpm_tag_t       out_tag_q;
  logic [PixW-1:0] level_d, level_q;
  logic [ProdW-1:0] scaled;

  assign adv        = !(out_tag_q.valid && out_stall_i);
  assign in_stall_o = !adv;

  // Treat a zero pixel as 1; flag ratios outside (0.5, 1).
  always_comb begin
    cur_fix         = (cur_pixel_i == '0) ? PixW'(1) : cur_pixel_i;
    ref_fix         = (ref_pixel_i == '0) ? PixW'(1) : ref_pixel_i;
    s0_tag_d.valid  = in_valid_i;
    s0_tag_d.sat_hi = (cur_fix >= ref_fix);
    s0_tag_d.sat_lo = !s0_tag_d.sat_hi && ({cur_fix, 1'b0} <= {1'b0, ref_fix});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else if (adv) begin
      s0_tag_q <= s0_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_cur_q <= cur_fix;
      s0_ref_q <= ref_fix;
    end
  end

  // Ratio y = floor(cur * 2^31 / ref), one quotient bit per stage.
  assign div_tag[0] = s0_tag_q;
  assign div_rem[0] = s0_cur_q;
  assign div_den[0] = s0_ref_q;
  assign div_quo[0] = '0;

  for (genvar k = 0; k < YW; k++) begin : g_div
    lrpm_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .tag_i  (div_tag[k]),
      .rem_i  (div_rem[k]),
      .den_i  (div_den[k]),
      .quo_i  (div_quo[k]),
      .tag_o  (div_tag[k+1]),
      .rem_o  (div_rem[k+1]),
      .den_o  (div_den[k+1]),
      .quo_o  (div_quo[k+1])
    );
  end

  // log2 of y by repeated squaring, one fraction bit per stage.
  assign log_tag[0]  = div_tag[YW];
  assign log_y[0]    = div_quo[YW];
  assign log_frac[0] = '0;

  for (genvar k = 0; k < LogFracBits; k++) begin : g_log
    lrpm_log_stage u_log (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .tag_i  (log_tag[k]),
      .y_i    (log_y[k]),
      .frac_i (log_frac[k]),
      .tag_o  (log_tag[k+1]),
      .y_o    (log_y[k+1]),
      .frac_o (log_frac[k+1])
    );
  end

  // Scale: (f * 65535) >> 24 as (f << 16) - f; f < 2^24 keeps it below 65535.
  always_comb begin
    scaled = {log_frac[LogFracBits], {PixW{1'b0}}}
           - {{PixW{1'b0}}, log_frac[LogFracBits]};
    priority if (log_tag[LogFracBits].sat_hi) begin
      level_d = LevelMax;
    end else if (log_tag[LogFracBits].sat_lo) begin
      level_d = '0;
    end else begin
      level_d = scaled[ProdW-1 -: PixW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tag_q <= '0;
    end else if (adv) begin
      out_tag_q <= log_tag[LogFracBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_q <= level_d;
    end
  end

  assign out_valid_o       = out_tag_q.valid;
  assign log_ratio_level_o = level_q;

  // Both saturation flags never mark one word.
  a_sat_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_tag[LogFracBits].valid |-> !(log_tag[LogFracBits].sat_hi &&
                                     log_tag[LogFracBits].sat_lo))
    else $error("both saturation flags set");

  // Equal pixels must saturate high at the input stage.
  a_equal_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cur_pixel_i == ref_pixel_i)) |=> s0_tag_q.sat_hi)
    else $error("equal pixels not flagged as saturated high");

  // In the mapped range the ratio is in [1, 2): top quotient bit is set.
  a_ratio_norm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_tag[YW].valid && !div_tag[YW].sat_hi && !div_tag[YW].sat_lo)
      |-> div_quo[YW][YW-1])
    else $error("ratio out of Q1.30 range");

  // A held output word keeps its level while stalled.
  a_hold_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(log_ratio_level_o)))
    else $error("output word changed under stall");

endmodule

[rtl/lrpm_div_stage.sv]
module lrpm_div_stage
  import lrpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  lrpm_tag_t       tag_i,
  input  logic [PixW-1:0] rem_i,
  input  logic [PixW-1:0] den_i,
  input  logic [YW-1:0]   quo_i,
  output lrpm_tag_t       tag_o,
  output logic [PixW-1:0] rem_o,
  output logic [PixW-1:0] den_o,
  output logic [YW-1:0]   quo_o
);

  lrpm_tag_t       tag_q;
  logic [PixW-1:0] rem_d, rem_q;
  logic [PixW-1:0] den_q;
  logic [YW-1:0]   quo_d, quo_q;
  logic [PixW:0]   dbl;
  logic [PixW:0]   diff;
  logic            take;

  // One restoring step: double the remainder, subtract the divisor if it fits.
  always_comb begin
    dbl   = {rem_i, 1'b0};
    diff  = dbl - {1'b0, den_i};
    take  = (dbl >= {1'b0, den_i});
    rem_d = take ? diff[PixW-1:0] : dbl[PixW-1:0];
    quo_d = {quo_i[YW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

[rtl/lrpm_log_stage.sv]
module lrpm_log_stage
  import lrpm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  lrpm_tag_t              tag_i,
  input  logic [YW-1:0]          y_i,
  input  logic [LogFracBits-1:0] frac_i,
  output lrpm_tag_t              tag_o,
  output logic [YW-1:0]          y_o,
  output logic [LogFracBits-1:0] frac_o
);

  lrpm_tag_t              tag_q;
  logic [2*YW-1:0]        sq;
  logic                   bit_set;
  logic [YW-1:0]          y_d, y_q;
  logic [LogFracBits-1:0] frac_d, frac_q;

  // Square in Q1.30; a square of 2 or more yields a one bit and is halved.
  always_comb begin
    sq      = y_i * y_i;
    bit_set = sq[2*YW-1];
    y_d     = bit_set ? sq[2*YW-1 -: YW] : sq[2*YW-2 -: YW];
    frac_d  = {frac_i[LogFracBits-2:0], bit_set};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q    <= y_d;
      frac_q <= frac_d;
    end
  end

  assign tag_o  = tag_q;
  assign y_o    = y_q;
  assign frac_o = frac_q;

endmodule

[tb/log_ratio_pixel_map_core_tb.sv]
`timescale 1ns / 1ps

module log_ratio_pixel_map_core_tb;
  import lrpm_pkg::*;

  // Drain long enough for the core's pipeline to empty.
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned IdlePct       = 36;

  typedef struct {
    logic [PixW-1:0] cur;
    logic [PixW-1:0] rp;
    logic [PixW-1:0] level;
  } level_expect_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [PixW-1:0] cur_pixel_i;
  logic [PixW-1:0] ref_pixel_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [PixW-1:0] log_ratio_level_o;

  level_expect_t level_expect_q[$];
  bit            fail_seen;
  bit            idle_on;
  bit            hold_off_req;
  int unsigned   cycle_count;

  log_ratio_pixel_map_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cur_pixel_i       (cur_pixel_i),
    .ref_pixel_i       (ref_pixel_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .log_ratio_level_o (log_ratio_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run: a lost or stuck word ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Compute the mapped level: log2 of 2*cur/ref found bit by bit on a Q1.30 ratio,
  // then scaled to 16 bits with truncation.
  function automatic logic [PixW-1:0] map_log_ratio(logic [PixW-1:0] cur_in,
                                                    logic [PixW-1:0] ref_in);
    logic [63:0] cur;
    logic [63:0] rp;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] level;
    int          k;
    cur = cur_in;
    rp  = ref_in;
    if (cur == 0) cur = 1;
    if (rp == 0) rp = 1;
    if (cur >= rp) return LevelMax;
    if (2 * cur <= rp) return '0;
    y    = (cur << (QFrac + 1)) / rp;
    frac = '0;
    for (k = 0; k < LogFracBits; k++) begin
      y    = (y * y) >> QFrac;
      frac = frac << 1;
      if (y >= (64'd2 << QFrac)) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    level = (frac * 64'(LevelMax)) >> LogFracBits;
    if (level > 64'(LevelMax)) level = 64'(LevelMax);
    return level[PixW-1:0];
  endfunction

  // Offer one pixel pair; hold it until taken, then record the level it must give.
  task automatic send_word(input logic [PixW-1:0] cur, input logic [PixW-1:0] rp);
    level_expect_t exp_item;
    while (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cur_pixel_i <= cur;
    ref_pixel_i <= rp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_item.cur   = cur;
    exp_item.rp    = rp;
    exp_item.level = map_log_ratio(cur, rp);
    level_expect_q.push_back(exp_item);
  endtask

  function automatic logic [PixW-1:0] corner_pixel();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 16'd1;
      2:       return LevelMax;
      default: return PixW'($urandom_range(65535));
    endcase
  endfunction

  // Mostly pairs inside the mapped band (half the reference up to the reference),
  // the rest full-range noise and saturation boundaries.
  task automatic pick_pixels(output logic [PixW-1:0] cur, output logic [PixW-1:0] rp);
    int unsigned sel;
    int unsigned rmax;
    sel = $urandom_range(99);
    if (sel < 70) begin
      rmax = ($urandom_range(4) == 0) ? 64 : 65535;
      rp   = PixW'($urandom_range(rmax, 3));
      cur  = PixW'($urandom_range(rp - 1, rp / 2 + 1));
    end else if (sel < 85) begin
      cur = PixW'($urandom_range(65535));
      rp  = PixW'($urandom_range(65535));
    end else begin
      case ($urandom_range(2))
        0: begin
          cur = corner_pixel();
          rp  = corner_pixel();
        end
        1: begin
          rp  = PixW'($urandom_range(65535, 2));
          cur = rp / 2 + PixW'($urandom_range(1));
        end
        default: begin
          rp  = PixW'($urandom_range(65535, 1));
          cur = rp - PixW'($urandom_range(1));
        end
      endcase
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    // zero pixels count as 1
    send_word(16'd0, 16'd0);
    send_word(16'd0, 16'd1);
    send_word(16'd1, 16'd0);
    send_word(16'd0, 16'd2);
    send_word(16'd0, 16'd3);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    // current at or above reference saturates high
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h8000, 16'h7FFF);
    // current at or below half the reference saturates low
    send_word(16'd1, 16'd2);
    send_word(16'h7FFF, 16'hFFFF);
    send_word(16'h0001, 16'hFFFF);
    // mapped band, both ends and the middle
    send_word(16'h8000, 16'hFFFF);
    send_word(16'hFFFE, 16'hFFFF);
    send_word(16'd2, 16'd3);
    send_word(16'd3, 16'd4);
    send_word(16'd3, 16'd5);
    send_word(16'h5555, 16'h8000);
    send_word(16'hAAAA, 16'hFFFF);
    send_word(16'hB505, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    logic [PixW-1:0] cur;
    logic [PixW-1:0] rp;
    idle_on = 1'b1;
    repeat (n) begin
      pick_pixels(cur, rp);
      send_word(cur, rp);
    end
  endtask

  task automatic test_back_to_back(input int unsigned n);
    logic [PixW-1:0] cur;
    logic [PixW-1:0] rp;
    idle_on = 1'b0;
    repeat (n) begin
      pick_pixels(cur, rp);
      send_word(cur, rp);
    end
    idle_on = 1'b1;
  endtask

  // Stall the output long enough that the pipe fills and pushes back on the input.
  task automatic test_output_hold_off(input int unsigned n);
    logic [PixW-1:0] cur;
    logic [PixW-1:0] rp;
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (n) begin
      pick_pixels(cur, rp);
      send_word(cur, rp);
    end
    idle_on = 1'b1;
  endtask

  // Receiver: check each level taken, then choose the stall for the next cycle.
  initial begin
    int unsigned     hold_left;
    level_expect_t   exp_item;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (level_expect_q.size() == 0) begin
          $error("log_ratio_level word with nothing expected: actual %0d",
                 log_ratio_level_o);
          fail_seen = 1'b1;
        end else begin
          exp_item = level_expect_q.pop_front();
          if (log_ratio_level_o !== exp_item.level) begin
            $error("log_ratio_level: expected %0d, actual %0d (cur_pixel %0d, ref_pixel %0d)",
                   exp_item.level, log_ratio_level_o, exp_item.cur, exp_item.rp);
            fail_seen = 1'b1;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin
    fail_seen    = 1'b0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    cycle_count  = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cur_pixel_i <= '0;
    ref_pixel_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(330);
    test_back_to_back(200);
    test_output_hold_off(150);

    in_valid_i <= 1'b0;
    // drain: wait out every expected level, then the pipe's latency
    while (level_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_seen) begin
      $display("Some tests failed");
    end else begin
      $display("All tests passed");
    end
    $finish;
  end

endmodule
